// ----- src/vau_pkg.sv -----
// ============================================================================
// vau_pkg
// Types, codes and the reciprocal table shared by the value approach unit.
// ============================================================================
package vau_pkg;

    // Fixed widths of the port fields
    localparam int OP_W     = 3;
    localparam int SHIFT_W  = 3;
    localparam int FIELD_W  = 16;
    localparam int AMOUNT_W = 15;
    localparam int INDEX_W  = 4;
    localparam int INV_W    = 12;
    localparam int INV_FRAC = 12;

    // Step modes
    typedef enum logic [OP_W-1:0] {
        OP_EXP   = 3'd0,
        OP_SNAP  = 3'd1,
        OP_PHASE = 3'd2,
        OP_RANGE = 3'd3,
        OP_SPEED = 3'd4,
        OP_TIME  = 3'd5
    } t_op;

    // Per-word control carried along the pipe
    typedef struct packed {
        t_op                 op;
        logic [SHIFT_W-1:0]  shift;
        logic [AMOUNT_W-1:0] amount;
        logic [INV_W-1:0]    inv;
    } t_ctrl;

    // 4096/t for the remaining step count; zero means jump to the goal
    function automatic logic [INV_W-1:0] recip_lookup(input logic [INDEX_W-1:0] idx);
        logic [INV_W-1:0] v;
        case (idx)
            4'd1:    v = 12'd2048;
            4'd2:    v = 12'd1365;
            4'd3:    v = 12'd1024;
            4'd4:    v = 12'd819;
            4'd5:    v = 12'd682;
            4'd6:    v = 12'd585;
            4'd7:    v = 12'd512;
            4'd8:    v = 12'd455;
            4'd9:    v = 12'd409;
            4'd10:   v = 12'd372;
            4'd11:   v = 12'd341;
            4'd12:   v = 12'd315;
            4'd13:   v = 12'd292;
            4'd14:   v = 12'd273;
            4'd15:   v = 12'd256;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/vau_unwrap.sv -----
// ============================================================================
// vau_unwrap
// First stage: widens the inputs, applies the angle unwrap when wrap_phase is
// set or the mode is phase, and forms the difference goal minus present.
// ============================================================================
module vau_unwrap #(
    parameter int VALUE_WIDTH = 16,
    parameter int ANGLE_BITS  = 12,
    parameter int EXT_WIDTH   = 19
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [vau_pkg::OP_W-1:0]           i_op,
    input  logic [vau_pkg::SHIFT_W-1:0]        i_shift,
    input  logic                               i_wrap_phase,
    input  logic signed [vau_pkg::FIELD_W-1:0] i_current,
    input  logic signed [vau_pkg::FIELD_W-1:0] i_target,
    input  logic [vau_pkg::AMOUNT_W-1:0]       i_amount,
    input  logic [vau_pkg::INDEX_W-1:0]        i_time_index,
    output logic                               o_valid,
    input  logic                               i_stall,
    output vau_pkg::t_ctrl                     o_ctrl,
    output logic signed [EXT_WIDTH-1:0]        o_c,
    output logic signed [EXT_WIDTH-1:0]        o_t,
    output logic signed [EXT_WIDTH-1:0]        o_d
);
    import vau_pkg::*;

    localparam int IN_W  = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int FULL  = 1 << ANGLE_BITS;
    localparam int HALF  = 1 << (ANGLE_BITS - 1);

    logic                        load;
    logic                        c_sign;
    logic                        t_sign;
    logic signed [EXT_WIDTH-1:0] c_x;
    logic signed [EXT_WIDTH-1:0] t_x;
    logic signed [EXT_WIDTH-1:0] diff;
    logic [ANGLE_BITS-1:0]       raw;
    logic [ANGLE_BITS:0]         e_u;
    logic signed [EXT_WIDTH-1:0] e_x;
    logic                        do_wrap;
    t_ctrl                       n_ctrl;
    logic signed [EXT_WIDTH-1:0] n_c;
    logic signed [EXT_WIDTH-1:0] n_d;

    logic                        r_valid;
    t_ctrl                       r_ctrl;
    logic signed [EXT_WIDTH-1:0] r_c;
    logic signed [EXT_WIDTH-1:0] r_t;
    logic signed [EXT_WIDTH-1:0] r_d;

    // stage moves when empty or when downstream takes the word
    assign load    = !r_valid || !i_stall;
    assign o_stall = !load;

    // Widen: sign-extend when the value width fits the port, else zero-extend
    assign c_sign = (VALUE_WIDTH <= FIELD_W) ? i_current[IN_W-1] : 1'b0;
    assign t_sign = (VALUE_WIDTH <= FIELD_W) ? i_target[IN_W-1]  : 1'b0;
    assign c_x    = $signed({{(EXT_WIDTH-IN_W){c_sign}}, i_current[IN_W-1:0]});
    assign t_x    = $signed({{(EXT_WIDTH-IN_W){t_sign}}, i_target[IN_W-1:0]});

    // Unwrap: offset modulo the angle range, folded into (-half, half]
    always_comb begin
        diff = c_x - t_x;
        raw  = diff[ANGLE_BITS-1:0];
        if ({1'b0, raw} > (ANGLE_BITS+1)'(HALF)) begin
            e_u = {1'b0, raw} - (ANGLE_BITS+1)'(FULL);
        end else begin
            e_u = {1'b0, raw};
        end
        e_x = $signed({{(EXT_WIDTH-ANGLE_BITS-1){e_u[ANGLE_BITS]}}, e_u});
    end

    assign do_wrap = i_wrap_phase || (i_op == OP_PHASE);

    always_comb begin
        if (do_wrap) begin
            n_c = t_x + e_x;
            n_d = -e_x;
        end else begin
            n_c = c_x;
            n_d = t_x - c_x;
        end
        n_ctrl.op     = t_op'(i_op);
        n_ctrl.shift  = i_shift;
        n_ctrl.amount = i_amount;
        n_ctrl.inv    = recip_lookup(i_time_index);
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_ctrl <= n_ctrl;
            r_c    <= n_c;
            r_t    <= t_x;
            r_d    <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_c     = r_c;
    assign o_t     = r_t;
    assign o_d     = r_d;

    // Difference always matches the registered present and goal values
    a_diff_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_t - r_c == r_d))
        else $error("stage one difference does not match its operands");

endmodule

// ----- src/vau_prep.sv -----
// ============================================================================
// vau_prep
// Second stage: power-of-two quotient, clamp bounds, speed step and the
// time-mode product.
// ============================================================================
module vau_prep #(
    parameter int EXT_WIDTH = 19
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  vau_pkg::t_ctrl                            i_ctrl,
    input  logic signed [EXT_WIDTH-1:0]               i_c,
    input  logic signed [EXT_WIDTH-1:0]               i_t,
    input  logic signed [EXT_WIDTH-1:0]               i_d,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output vau_pkg::t_ctrl                            o_ctrl,
    output logic signed [EXT_WIDTH-1:0]               o_c,
    output logic signed [EXT_WIDTH-1:0]               o_t,
    output logic signed [EXT_WIDTH-1:0]               o_q,
    output logic signed [EXT_WIDTH-1:0]               o_lo,
    output logic signed [EXT_WIDTH-1:0]               o_hi,
    output logic signed [EXT_WIDTH-1:0]               o_n,
    output logic                                      o_dz,
    output logic                                      o_dpos,
    output logic signed [EXT_WIDTH+vau_pkg::INV_W:0]  o_prod
);
    import vau_pkg::*;

    localparam int PROD_W = EXT_WIDTH + INV_W + 1;

    logic                        load;
    logic signed [EXT_WIDTH-1:0] bias;
    logic signed [EXT_WIDTH-1:0] qsum;
    logic signed [EXT_WIDTH-1:0] amt_x;
    logic signed [INV_W:0]       inv_s;
    logic signed [EXT_WIDTH-1:0] n_q;
    logic signed [EXT_WIDTH-1:0] n_n;
    logic signed [PROD_W-1:0]    n_prod;

    logic                        r_valid;
    t_ctrl                       r_ctrl;
    logic signed [EXT_WIDTH-1:0] r_c;
    logic signed [EXT_WIDTH-1:0] r_t;
    logic signed [EXT_WIDTH-1:0] r_q;
    logic signed [EXT_WIDTH-1:0] r_lo;
    logic signed [EXT_WIDTH-1:0] r_hi;
    logic signed [EXT_WIDTH-1:0] r_n;
    logic                        r_dz;
    logic                        r_dpos;
    logic signed [PROD_W-1:0]    r_prod;

    assign load    = !r_valid || !i_stall;
    assign o_stall = !load;

    // d / 2^k truncated toward zero: bias negatives before the shift
    always_comb begin
        if (i_d[EXT_WIDTH-1]) begin
            bias = $signed((EXT_WIDTH'(1) << i_ctrl.shift) - EXT_WIDTH'(1));
        end else begin
            bias = '0;
        end
        qsum = i_d + bias;
        n_q  = qsum >>> i_ctrl.shift;
    end

    // Speed step in the direction of the goal
    assign amt_x = $signed({{(EXT_WIDTH-AMOUNT_W){1'b0}}, i_ctrl.amount});
    assign n_n   = (i_d > 0) ? (i_c + amt_x) : (i_c - amt_x);

    // Time mode: d times the 4096/t reciprocal
    assign inv_s  = $signed({1'b0, i_ctrl.inv});
    assign n_prod = i_d * inv_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_ctrl <= i_ctrl;
            r_c    <= i_c;
            r_t    <= i_t;
            r_q    <= n_q;
            r_lo   <= i_t - amt_x;
            r_hi   <= i_t + amt_x;
            r_n    <= n_n;
            r_dz   <= (i_d == '0);
            r_dpos <= (i_d > 0);
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_c     = r_c;
    assign o_t     = r_t;
    assign o_q     = r_q;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_n     = r_n;
    assign o_dz    = r_dz;
    assign o_dpos  = r_dpos;
    assign o_prod  = r_prod;

endmodule

// ----- src/vau_select.sv -----
// ============================================================================
// vau_select
// Third stage: per-mode decisions, result selection and the output register.
// ============================================================================
module vau_select #(
    parameter int VALUE_WIDTH = 16,
    parameter int EXT_WIDTH   = 19
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  vau_pkg::t_ctrl                            i_ctrl,
    input  logic signed [EXT_WIDTH-1:0]               i_c,
    input  logic signed [EXT_WIDTH-1:0]               i_t,
    input  logic signed [EXT_WIDTH-1:0]               i_q,
    input  logic signed [EXT_WIDTH-1:0]               i_lo,
    input  logic signed [EXT_WIDTH-1:0]               i_hi,
    input  logic signed [EXT_WIDTH-1:0]               i_n,
    input  logic                                      i_dz,
    input  logic                                      i_dpos,
    input  logic signed [EXT_WIDTH+vau_pkg::INV_W:0]  i_prod,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [vau_pkg::FIELD_W-1:0]        o_next_value
);
    import vau_pkg::*;

    localparam int PROD_W = EXT_WIDTH + INV_W + 1;
    localparam int OUT_W  = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

    logic                        load;
    logic signed [EXT_WIDTH-1:0] amt_x;
    logic signed [EXT_WIDTH-1:0] cq;
    logic signed [EXT_WIDTH-1:0] cstep;
    logic signed [PROD_W-1:0]    tbias;
    logic signed [PROD_W-1:0]    tsum;
    logic signed [PROD_W-1:0]    tdiv;
    logic signed [EXT_WIDTH-1:0] tres;
    logic signed [EXT_WIDTH-1:0] res;
    logic [FIELD_W-1:0]          n_next;

    logic                        r_valid;
    logic [FIELD_W-1:0]          r_next;

    assign load    = !r_valid || !i_stall;
    assign o_stall = !load;

    assign amt_x = $signed({{(EXT_WIDTH-AMOUNT_W){1'b0}}, i_ctrl.amount});
    assign cq    = i_c + i_q;
    assign cstep = i_dpos ? (i_c + EXT_WIDTH'(1)) : (i_c - EXT_WIDTH'(1));

    // product / 4096 truncated toward zero, then added to present value
    always_comb begin
        tbias = i_prod[PROD_W-1] ? $signed(PROD_W'(12'hFFF)) : '0;
        tsum  = i_prod + tbias;
        tdiv  = tsum >>> INV_FRAC;
        tres  = tdiv[EXT_WIDTH-1:0] + i_c;
    end

    // Mode select
    always_comb begin
        case (i_ctrl.op)
            OP_EXP: begin
                if (i_dz) begin
                    res = i_t;
                end else if (i_q == '0) begin
                    res = cstep;
                end else begin
                    res = cq;
                end
            end
            OP_SNAP: begin
                res = ((i_q > -amt_x) && (i_q < amt_x)) ? i_t : cq;
            end
            OP_PHASE: begin
                res = i_c;
            end
            OP_RANGE: begin
                if (i_c < i_lo) begin
                    res = i_lo;
                end else if (i_c > i_hi) begin
                    res = i_hi;
                end else begin
                    res = i_c;
                end
            end
            OP_SPEED: begin
                if (i_dpos) begin
                    res = (i_n >= i_t) ? i_t : i_n;
                end else begin
                    res = (i_n <= i_t) ? i_t : i_n;
                end
            end
            OP_TIME: begin
                res = (i_ctrl.inv == '0) ? i_t : tres;
            end
            default: begin
                res = i_c;
            end
        endcase
        // wrap to the value width, then into the port
        n_next = FIELD_W'(res[OUT_W-1:0]);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_next <= n_next;
        end
    end

    assign o_valid      = r_valid;
    assign o_next_value = $signed(r_next);

endmodule

// ----- src/value_approach_unit.sv -----
// ============================================================================
// value_approach_unit
// Steps a present value toward a goal in one of several modes, with an
// optional angle unwrap in front.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | to block  | i_valid / o_stall    | op, shift, wrap_phase,
//           |           |                      | current, target, amount,
//           |           |                      | time_index
//   out     | from block| o_valid / i_stall    | next_value
//
// One word per cycle while the output is not stalled; three register stages,
// unwrap, prepare and select, the last one being the output register.
// The time-mode multiply sits in the prepare stage.
// Reset (synchronous, active low) clears the stage valid bits only.
// A stall holds only the stages that are full; bubbles close up behind it.
// ============================================================================
module value_approach_unit #(
    parameter int VALUE_WIDTH = 16,
    parameter int ANGLE_BITS  = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [vau_pkg::OP_W-1:0]           i_op,
    input  logic [vau_pkg::SHIFT_W-1:0]        i_shift,
    input  logic                               i_wrap_phase,
    input  logic signed [vau_pkg::FIELD_W-1:0] i_current,
    input  logic signed [vau_pkg::FIELD_W-1:0] i_target,
    input  logic [vau_pkg::AMOUNT_W-1:0]       i_amount,
    input  logic [vau_pkg::INDEX_W-1:0]        i_time_index,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [vau_pkg::FIELD_W-1:0] o_next_value
);
    import vau_pkg::*;

    // internal width: widest operand plus headroom for unwrap, d and bounds
    localparam int BASE_W  = (VALUE_WIDTH > ANGLE_BITS) ? VALUE_WIDTH : ANGLE_BITS;
    localparam int BASE2_W = (BASE_W > FIELD_W) ? BASE_W : FIELD_W;
    localparam int EXT_W   = BASE2_W + 3;
    localparam int PROD_W  = EXT_W + INV_W + 1;

    logic                    s1_valid;
    logic                    s1_stall;
    t_ctrl                   s1_ctrl;
    logic signed [EXT_W-1:0] s1_c;
    logic signed [EXT_W-1:0] s1_t;
    logic signed [EXT_W-1:0] s1_d;

    logic                    s2_valid;
    logic                    s2_stall;
    t_ctrl                   s2_ctrl;
    logic signed [EXT_W-1:0] s2_c;
    logic signed [EXT_W-1:0] s2_t;
    logic signed [EXT_W-1:0] s2_q;
    logic signed [EXT_W-1:0] s2_lo;
    logic signed [EXT_W-1:0] s2_hi;
    logic signed [EXT_W-1:0] s2_n;
    logic                    s2_dz;
    logic                    s2_dpos;
    logic signed [PROD_W-1:0] s2_prod;

    // Stage one: unwrap and difference
    vau_unwrap #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .ANGLE_BITS  (ANGLE_BITS),
        .EXT_WIDTH   (EXT_W)
    ) u_unwrap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_shift      (i_shift),
        .i_wrap_phase (i_wrap_phase),
        .i_current    (i_current),
        .i_target     (i_target),
        .i_amount     (i_amount),
        .i_time_index (i_time_index),
        .o_valid      (s1_valid),
        .i_stall      (s1_stall),
        .o_ctrl       (s1_ctrl),
        .o_c          (s1_c),
        .o_t          (s1_t),
        .o_d          (s1_d)
    );

    // Stage two: quotient, bounds, product
    vau_prep #(
        .EXT_WIDTH (EXT_W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_stall (s1_stall),
        .i_ctrl  (s1_ctrl),
        .i_c     (s1_c),
        .i_t     (s1_t),
        .i_d     (s1_d),
        .o_valid (s2_valid),
        .i_stall (s2_stall),
        .o_ctrl  (s2_ctrl),
        .o_c     (s2_c),
        .o_t     (s2_t),
        .o_q     (s2_q),
        .o_lo    (s2_lo),
        .o_hi    (s2_hi),
        .o_n     (s2_n),
        .o_dz    (s2_dz),
        .o_dpos  (s2_dpos),
        .o_prod  (s2_prod)
    );

    // Stage three: select and output register
    vau_select #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .EXT_WIDTH   (EXT_W)
    ) u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s2_valid),
        .o_stall      (s2_stall),
        .i_ctrl       (s2_ctrl),
        .i_c          (s2_c),
        .i_t          (s2_t),
        .i_q          (s2_q),
        .i_lo         (s2_lo),
        .i_hi         (s2_hi),
        .i_n          (s2_n),
        .i_dz         (s2_dz),
        .i_dpos       (s2_dpos),
        .i_prod       (s2_prod),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_next_value (o_next_value)
    );

    // Input is held off only when every stage holds a word
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (s1_valid && s2_valid && o_valid))
        else $error("input stalled with a free pipeline stage");

    // A result only appears after a word sat in the prepare stage
    a_out_from_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s2_valid))
        else $error("output valid without a word in the prepare stage");

    // An accepted word never vanishes from stage one while downstream stalls
    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s1_stall) |=> s1_valid)
        else $error("stalled stage one word lost");

endmodule

// ----- tb/sv/value_approach_checker.sv -----
// ----------------------------------------------------------------------------
// value_approach_checker
// Watches both channels of the value approach unit. Every accepted input word
// is stepped through a behavioural copy of the unit, and each accepted output
// word is compared with the oldest predicted next value.
// ----------------------------------------------------------------------------
module value_approach_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [vau_pkg::OP_W-1:0]           i_op,
    input  logic [vau_pkg::SHIFT_W-1:0]        i_shift,
    input  logic                               i_wrap_phase,
    input  logic signed [vau_pkg::FIELD_W-1:0] i_current,
    input  logic signed [vau_pkg::FIELD_W-1:0] i_target,
    input  logic [vau_pkg::AMOUNT_W-1:0]       i_amount,
    input  logic [vau_pkg::INDEX_W-1:0]        i_time_index,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [vau_pkg::FIELD_W-1:0] i_next_value,
    output int                                 o_mismatches,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import vau_pkg::*;

    localparam int     ANGLE_BITS = 12;
    localparam longint ANGLE_SPAN = longint'(1) << ANGLE_BITS;
    localparam longint ANGLE_HALF = ANGLE_SPAN / 2;
    localparam longint Q12_ONE    = 4096;

    logic signed [FIELD_W-1:0] next_value_q [$];
    logic signed [FIELD_W-1:0] oldest;

    // 4096/n for n remaining steps, zero meaning jump straight to the goal
    function automatic longint steps_to_q12(input logic [INDEX_W-1:0] idx);
        longint v;
        case (idx)
            4'd1:    v = 2048;
            4'd2:    v = 1365;
            4'd3:    v = 1024;
            4'd4:    v = 819;
            4'd5:    v = 682;
            4'd6:    v = 585;
            4'd7:    v = 512;
            4'd8:    v = 455;
            4'd9:    v = 409;
            4'd10:   v = 372;
            4'd11:   v = 341;
            4'd12:   v = 315;
            4'd13:   v = 292;
            4'd14:   v = 273;
            4'd15:   v = 256;
            default: v = 0;
        endcase
        return v;
    endfunction

    // Next value for one word, at full precision and wrapped at the end
    function automatic logic signed [FIELD_W-1:0] approach_next(
        input logic [OP_W-1:0]           op,
        input logic [SHIFT_W-1:0]        shift,
        input logic                      wrap,
        input logic signed [FIELD_W-1:0] current,
        input logic signed [FIELD_W-1:0] target,
        input logic [AMOUNT_W-1:0]       amount,
        input logic [INDEX_W-1:0]        time_index
    );
        longint c, t, d, den, amt, q, n, e, inv, r;
        c   = longint'(current);
        t   = longint'(target);
        amt = longint'(amount);
        den = longint'(1) << shift;

        // pull the present value to the copy nearest the goal
        if (wrap || op == OP_PHASE) begin
            e = (c - t) & (ANGLE_SPAN - 1);
            if (e > ANGLE_HALF)
                e = e - ANGLE_SPAN;
            c = t + e;
        end

        case (op)
            OP_EXP: begin
                d = t - c;
                if (d == 0) begin
                    r = t;
                end else begin
                    // minimum step of one
                    if (d > -den && d < den)
                        d = (d > 0) ? den : -den;
                    r = c + d / den;
                end
            end
            OP_SNAP: begin
                q = (t - c) / den;
                r = (q > -amt && q < amt) ? t : c + q;
            end
            OP_RANGE: begin
                if (c < t - amt)
                    r = t - amt;
                else if (c > t + amt)
                    r = t + amt;
                else
                    r = c;
            end
            OP_SPEED: begin
                if (c < t) begin
                    n = c + amt;
                    r = (n >= t) ? t : n;
                end else begin
                    n = c - amt;
                    r = (n <= t) ? t : n;
                end
            end
            OP_TIME: begin
                inv = steps_to_q12(time_index);
                r = (inv == 0) ? t : (t - c) * inv / Q12_ONE + c;
            end
            default: r = c;   // phase only and the spare codes
        endcase
        return r[FIELD_W-1:0];
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // compare before predicting: a word never leaves in the cycle it enters
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (next_value_q.size() == 0) begin
                    $error("next_value word with nothing pending: actual %0d", i_next_value);
                    o_mismatches++;
                end else begin
                    oldest = next_value_q.pop_front();
                    if (i_next_value !== oldest) begin
                        $error("next_value mismatch: expected %0d, actual %0d",
                               oldest, i_next_value);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                next_value_q.push_back(approach_next(i_op, i_shift, i_wrap_phase, i_current,
                                                     i_target, i_amount, i_time_index));
            o_pending = next_value_q.size();
        end
    end

endmodule

// ----- tb/sv/value_approach_unit_tb.sv -----
// ----------------------------------------------------------------------------
// value_approach_unit_tb
// Drives the value approach unit with a directed set of corner words and then
// three random phases with different idle patterns on each side, including a
// long output hold-off that backs the pipe up. Checking is left to the
// checker instance; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module value_approach_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vau_pkg::*;

    // op codes with no mode behind them
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int VAL_MIN        = -32768;
    localparam int VAL_MAX        = 32767;
    localparam int AMT_MAX        = 32767;
    localparam int PHASE_WORDS    = 410;
    localparam int SQUEEZE_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [SHIFT_W-1:0]        shift;
        logic                      wrap;
        logic signed [FIELD_W-1:0] current;
        logic signed [FIELD_W-1:0] target;
        logic [AMOUNT_W-1:0]       amount;
        logic [INDEX_W-1:0]        time_index;
    } t_step_word;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_valid      = 1'b0;
    logic                      o_stall;
    logic [OP_W-1:0]           i_op         = '0;
    logic [SHIFT_W-1:0]        i_shift      = '0;
    logic                      i_wrap_phase = 1'b0;
    logic signed [FIELD_W-1:0] i_current    = '0;
    logic signed [FIELD_W-1:0] i_target     = '0;
    logic [AMOUNT_W-1:0]       i_amount     = '0;
    logic [INDEX_W-1:0]        i_time_index = '0;
    logic                      o_valid;
    logic                      i_stall      = 1'b0;
    logic signed [FIELD_W-1:0] o_next_value;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit squeeze_req   = 1'b0;

    always #5 i_clk = ~i_clk;

    value_approach_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_shift      (i_shift),
        .i_wrap_phase (i_wrap_phase),
        .i_current    (i_current),
        .i_target     (i_target),
        .i_amount     (i_amount),
        .i_time_index (i_time_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_next_value (o_next_value)
    );

    value_approach_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_op         (i_op),
        .i_shift      (i_shift),
        .i_wrap_phase (i_wrap_phase),
        .i_current    (i_current),
        .i_target     (i_target),
        .i_amount     (i_amount),
        .i_time_index (i_time_index),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_next_value (o_next_value),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic t_step_word make_word(input logic [OP_W-1:0] op, input int shift,
                                             input bit wrap, input int cur, input int tgt,
                                             input int amt, input int idx);
        t_step_word w;
        w.op         = op;
        w.shift      = shift[SHIFT_W-1:0];
        w.wrap       = wrap;
        w.current    = cur[FIELD_W-1:0];
        w.target     = tgt[FIELD_W-1:0];
        w.amount     = amt[AMOUNT_W-1:0];
        w.time_index = idx[INDEX_W-1:0];
        return w;
    endfunction

    // full range, the extremes, or something near zero
    function automatic int pick_level();
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 3) == 0 ? VAL_MIN :
                         $urandom_range(0, 2) == 0 ? VAL_MAX : $urandom_range(0, 1) - 1;
            1:       v = int'($urandom_range(0, 128)) - 64;
            default: v = int'($urandom_range(0, 65535)) + VAL_MIN;
        endcase
        return v;
    endfunction

    function automatic t_step_word random_word();
        t_step_word w;
        int cur, tgt, amt;
        cur = pick_level();
        // half the goals lie close to the present value, some within an angle turn
        case ($urandom_range(0, 3))
            0:       tgt = cur + int'($urandom_range(0, 600)) - 300;
            1:       tgt = cur + int'($urandom_range(0, 8192)) - 4096;
            default: tgt = pick_level();
        endcase
        case ($urandom_range(0, 7))
            0, 1:    amt = $urandom_range(0, AMT_MAX);
            2, 3:    amt = $urandom_range(0, 20);
            4:       amt = 0;
            5:       amt = AMT_MAX;
            default: amt = $urandom_range(0, 2000);
        endcase
        w = make_word(OP_EXP, 0, 1'($urandom_range(0, 1)), cur, tgt, amt,
                      int'($urandom_range(0, 15)));
        w.op    = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                                : OP_W'($urandom_range(OP_EXP, OP_TIME));
        w.shift = ($urandom_range(0, 7) == 0) ? SHIFT_W'($urandom_range(0, 7))
                                               : SHIFT_W'($urandom_range(1, 4));
        return w;
    endfunction

    // present one word, with random gaps in front, and wait for it to be taken
    task automatic offer_word(input t_step_word w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= w.op;
        i_shift      <= w.shift;
        i_wrap_phase <= w.wrap;
        i_current    <= w.current;
        i_target     <= w.target;
        i_amount     <= w.amount;
        i_time_index <= w.time_index;
        do @(posedge i_clk); while (o_stall);
    endtask

    // output side: random stalls, and once a long hold-off
    initial begin : receiver
        int hold_left;
        bit squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (squeeze_req && !squeezed) begin
                hold_left = SQUEEZE_CYCLES;
                squeezed  = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner words, back to back
        offer_word(make_word(OP_EXP,   1, 0, 0,       0,       0,       0));
        offer_word(make_word(OP_EXP,   4, 0, 0,       5,       0,       0));
        offer_word(make_word(OP_EXP,   2, 0, 100,     -3,      0,       0));
        offer_word(make_word(OP_EXP,   0, 0, VAL_MIN, VAL_MAX, 0,       0));
        offer_word(make_word(OP_EXP,   7, 0, VAL_MAX, VAL_MIN, 0,       15));
        offer_word(make_word(OP_EXP,   3, 1, VAL_MIN, VAL_MAX, 0,       0));
        offer_word(make_word(OP_SNAP,  2, 0, 0,       1000,    0,       0));
        offer_word(make_word(OP_SNAP,  1, 0, 0,       15,      10,      0));
        offer_word(make_word(OP_SNAP,  3, 0, VAL_MIN, VAL_MAX, AMT_MAX, 0));
        offer_word(make_word(OP_SNAP,  5, 1, 300,     -9000,   1,       0));
        offer_word(make_word(OP_PHASE, 1, 0, 4000,    0,       0,       0));
        offer_word(make_word(OP_PHASE, 1, 0, 2048,    0,       0,       0));
        offer_word(make_word(OP_PHASE, 1, 0, 2049,    0,       0,       0));
        offer_word(make_word(OP_RANGE, 1, 0, 5,       10,      0,       0));
        offer_word(make_word(OP_RANGE, 1, 0, VAL_MIN, VAL_MAX, AMT_MAX, 0));
        offer_word(make_word(OP_RANGE, 1, 0, 1000,    0,       100,     0));
        offer_word(make_word(OP_SPEED, 1, 0, 3,       3,       0,       0));
        offer_word(make_word(OP_SPEED, 1, 0, -5,      5,       0,       0));
        offer_word(make_word(OP_SPEED, 1, 0, VAL_MIN, VAL_MAX, AMT_MAX, 0));
        offer_word(make_word(OP_SPEED, 1, 1, 1000,    0,       50,      0));
        offer_word(make_word(OP_TIME,  1, 0, 123,     -456,    0,       0));
        offer_word(make_word(OP_TIME,  1, 0, VAL_MIN, VAL_MAX, 0,       1));
        offer_word(make_word(OP_TIME,  6, 1, VAL_MAX, VAL_MIN, 0,       15));
        offer_word(make_word(OP_SPARE_LO, 1, 1, 5000, 0,       0,       7));
        offer_word(make_word(OP_SPARE_HI, 1, 0, -1,   1,       0,       0));

        // sender sparse, receiver busy; then swapped; then flat out with a hold-off
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    squeeze_req   = 1'b1;
                end
            endcase
            repeat (PHASE_WORDS) offer_word(random_word());
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
